[hdl/mpas_pkg.sv]
// ----------------------------------------------------------------------------
// mpas_pkg
// Constants and header checks for the MPEG audio sync locator.
// ----------------------------------------------------------------------------
`default_nettype none

package mpas_pkg;

  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam logic [15:0] SEARCH_LIMIT_RST  = 16'd2048;
  localparam logic [23:0] ID3_TAG           = 24'h494433;
  localparam logic [31:0] AID_TAG           = 32'h41694401;
  localparam logic [15:0] AID_HDR_LEN       = 16'd6;

  // Layer II bitrate/mode exclusion mask, indexed by bitrate index
  function automatic logic [3:0] layer2_bad(input logic [3:0] idx);
    logic [3:0] m;
    case (idx)
      4'd1, 4'd2, 4'd3, 4'd5: m = 4'd7;
      4'd11, 4'd12, 4'd13, 4'd14, 4'd15: m = 4'd8;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

  function automatic logic header_ok(input logic [31:0] w);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [3:0] bad;
    logic       ok;
    b0  = w[31:24];
    b1  = w[23:16];
    b2  = w[15:8];
    b3  = w[7:0];
    bad = layer2_bad(b2[7:4]);
    ok  = 1'b1;
    if (b0 != 8'hFF) ok = 1'b0;
    if ((b1 & 8'hE0) != 8'hE0) ok = 1'b0;
    if ((b1 & 8'h18) == 8'h08) ok = 1'b0;
    if ((b1 & 8'h06) == 8'h00) ok = 1'b0;
    if ((b2 & 8'hF0) == 8'hF0) ok = 1'b0;
    if ((b2 & 8'h0C) == 8'h0C) ok = 1'b0;
    if (((b1 & 8'h18) == 8'h18) && ((b1 & 8'h06) == 8'h04) && bad[b3[7:6]]) ok = 1'b0;
    if (b3[1:0] == 2'd2) ok = 1'b0;
    return ok;
  endfunction

endpackage

`default_nettype wire

[hdl/mpeg_audio_sync_locator.sv]
// ----------------------------------------------------------------------------
// mpeg_audio_sync_locator
// Skips ID3v2 tag and album-ID block, then slides a 4-byte window to the first
// valid MPEG 1/2/2.5 Layer I-III frame header; reports header word and offset.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tdata: data_byte; tuser: restart
//  out_    | out | out_tvalid/out_tready | tdata: header_offset, header_word;
//          |     |                       | tuser: status
//  cfg_    | in  | cfg_we                | cfg_wdata: search_limit
//
//  One byte per cycle while in_tready is high; all work for a byte is one
//  pass between the state registers and the result register.
//  The result appears in the cycle after the byte that ends the search.
//  in_tready drops only while a result is held and out_tready is low.
//  rst_n (synchronous) clears the search state and loads search_limit = 2048.
// ----------------------------------------------------------------------------
`default_nettype none

module mpeg_audio_sync_locator #(
  parameter int unsigned POSITION_BITS = mpas_pkg::POSITION_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,   // search_limit
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  input  wire logic        in_tuser,    // [0] restart
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [63:0] out_tdata,   // [31:0] header_offset, [63:32] header_word
  output      logic        out_tuser    // [0] status
);

  typedef enum logic [3:0] {
    PH_HEAD, PH_TAG_TAIL, PH_SKIP_TAG, PH_AFTER_TAG, PH_AID_LEN,
    PH_SKIP_AID, PH_AFTER_AID, PH_SEARCH, PH_DONE
  } phase_t;

  localparam int unsigned PB = POSITION_BITS;

  phase_t              phase_r, phase_nxt;
  logic [PB-1:0]       pos_r, pos_nxt;
  logic [31:0]         win_r, win_nxt;
  logic [2:0]          gc_r, gc_nxt;
  logic [27:0]         skip_r, skip_nxt;
  logic [15:0]         fails_r, fails_nxt;
  logic [15:0]         limit_r;
  logic                ov_r, ov_nxt;
  logic                st_r, st_nxt;
  logic [31:0]         off_r, off_nxt;
  logic [31:0]         word_r, word_nxt;

  phase_t              ph;
  logic [PB-1:0]       pos;
  logic [31:0]         win;
  logic [2:0]          gc;
  logic [27:0]         skip;
  logic [15:0]         fails;
  logic [31:0]         shwin;
  logic [27:0]         skip_dec;
  logic [27:0]         tag_skip;
  logic [15:0]         aid_len;
  logic [15:0]         fails_inc;
  logic [15:0]         limit_eff;
  logic [PB-1:0]       pos_m3;
  logic [PB+31:0]      pos_ext;
  logic                accept;
  logic                emit;
  logic                do_test;
  logic                chk_aid;
  logic                hdr_ok;

  assign accept = in_tvalid && in_tready;
  assign in_tready = !ov_r || out_tready;

  always_comb begin
    ph    = in_tuser ? PH_HEAD : phase_r;
    pos   = in_tuser ? '0 : pos_r;
    win   = in_tuser ? '0 : win_r;
    gc    = in_tuser ? '0 : gc_r;
    skip  = in_tuser ? '0 : skip_r;
    fails = in_tuser ? '0 : fails_r;

    shwin     = {win[23:0], in_tdata};
    skip_dec  = (skip != '0) ? skip - 28'd1 : skip;
    tag_skip  = {skip[20:0], in_tdata[6:0]};
    aid_len   = {in_tdata, skip[7:0]};
    fails_inc = (fails != 16'hFFFF) ? fails + 16'd1 : fails;
    limit_eff = (limit_r != '0) ? limit_r : 16'd1;
    hdr_ok    = mpas_pkg::header_ok(shwin);
    pos_m3    = pos - PB'(3);
    pos_ext   = {32'b0, pos_m3};

    phase_nxt = ph;
    pos_nxt   = pos + PB'(1);
    win_nxt   = win;
    gc_nxt    = gc;
    skip_nxt  = skip;
    fails_nxt = fails;
    do_test   = 1'b0;
    chk_aid   = 1'b0;

    case (ph)
      PH_HEAD: begin
        win_nxt = shwin;
        gc_nxt  = gc + 3'd1;
        if (gc == 3'd3) begin
          if (shwin[31:8] == mpas_pkg::ID3_TAG) begin
            phase_nxt = PH_TAG_TAIL;
            gc_nxt    = '0;
            skip_nxt  = '0;
          end else begin
            chk_aid = 1'b1;
          end
        end
      end
      PH_TAG_TAIL: begin
        if (gc >= 3'd2) skip_nxt = tag_skip;
        gc_nxt = gc + 3'd1;
        if (gc == 3'd5) begin
          if (skip_nxt == '0) begin
            phase_nxt = PH_AFTER_TAG;
            gc_nxt    = '0;
          end else begin
            phase_nxt = PH_SKIP_TAG;
          end
        end
      end
      PH_SKIP_TAG, PH_SKIP_AID: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = (ph == PH_SKIP_TAG) ? PH_AFTER_TAG : PH_AFTER_AID;
          gc_nxt    = '0;
        end
      end
      PH_AFTER_TAG: begin
        win_nxt = shwin;
        gc_nxt  = gc + 3'd1;
        if (gc == 3'd3) chk_aid = 1'b1;
      end
      PH_AID_LEN: begin
        if (gc == '0) begin
          skip_nxt = {20'b0, in_tdata};
          gc_nxt   = 3'd1;
        end else begin
          skip_nxt = (aid_len > mpas_pkg::AID_HDR_LEN) ?
                     {12'b0, aid_len - mpas_pkg::AID_HDR_LEN} : '0;
          if (skip_nxt == '0) begin
            phase_nxt = PH_AFTER_AID;
            gc_nxt    = '0;
          end else begin
            phase_nxt = PH_SKIP_AID;
          end
        end
      end
      PH_AFTER_AID: begin
        win_nxt = shwin;
        gc_nxt  = gc + 3'd1;
        if (gc == 3'd3) do_test = 1'b1;
      end
      PH_SEARCH: begin
        win_nxt = shwin;
        do_test = 1'b1;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    if (chk_aid) begin
      if (shwin == mpas_pkg::AID_TAG) begin
        phase_nxt = PH_AID_LEN;
        gc_nxt    = '0;
        skip_nxt  = '0;
      end else begin
        do_test = 1'b1;
      end
    end

    emit   = 1'b0;
    st_nxt = st_r;
    if (do_test) begin
      if (hdr_ok) begin
        emit   = 1'b1;
        st_nxt = 1'b0;
      end else begin
        fails_nxt = fails_inc;
        if (fails_inc < limit_eff) begin
          phase_nxt = PH_SEARCH;
        end else begin
          emit   = 1'b1;
          st_nxt = 1'b1;
        end
      end
      if (emit) phase_nxt = PH_DONE;
    end

    off_nxt  = emit ? pos_ext[31:0] : off_r;
    word_nxt = emit ? shwin : word_r;
    if (accept && emit) begin
      ov_nxt = 1'b1;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
      pos_r   <= '0;
      win_r   <= '0;
      gc_r    <= '0;
      skip_r  <= '0;
      fails_r <= '0;
      limit_r <= mpas_pkg::SEARCH_LIMIT_RST;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (accept) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        win_r   <= win_nxt;
        gc_r    <= gc_nxt;
        skip_r  <= skip_nxt;
        fails_r <= fails_nxt;
      end
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      st_r   <= st_nxt;
      off_r  <= off_nxt;
      word_r <= word_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {word_r, off_r};
  assign out_tuser  = st_r;

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_tuser && phase_r == PH_DONE) |=> (phase_r == PH_DONE))
    else $error("search resumed after result without restart");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit) |=> (phase_r == PH_DONE && out_tvalid))
    else $error("result emitted without entering done phase");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP_TAG || phase_r == PH_SKIP_AID) |-> (skip_r != '0))
    else $error("skip phase with zero remaining count");

endmodule

`default_nettype wire
